// File: sv/bascd_pkg.sv
// Shared definitions for the bitmap/attribute screen decoder.
// Holds request codes, store geometry, the queued request type and the palette.
// No dependencies.
`default_nettype none

package bascd_pkg;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_RENDER = 2'd1;
  localparam logic [1:0] OP_FRAME  = 2'd2;

  localparam int STORE_BYTES = 6912;
  localparam int ATTR_BASE   = 6144;
  localparam int SCREEN_ROWS = 192;
  localparam int ADDR_W      = 13;

  localparam logic [7:0] LEVEL_NORMAL = 8'hcd;
  localparam logic [7:0] LEVEL_BRIGHT = 8'hff;

  // One classified request as it sits in the queue. For a render, addr holds
  // the bitmap byte address; for a write it holds the store address.
  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] attr_addr;
    logic [7:0]        data;
    logic [7:0]        row;
    logic [4:0]        col;
  } bascd_cmd_t;

  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [7:0] lvl;
    begin
      lvl = idx[3] ? LEVEL_BRIGHT : LEVEL_NORMAL;
      return {(idx[1] ? lvl : 8'h00), (idx[2] ? lvl : 8'h00), (idx[0] ? lvl : 8'h00)};
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/bascd_front.sv
// Front end of the screen decoder: takes requests and classifies them.
// Computes store addresses for renders and drops requests that do nothing.
// Depends on bascd_pkg.
`default_nettype none

module bascd_front
  import bascd_pkg::*;
(
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [12:0] in_mem_address,
  input  wire logic [7:0]  in_mem_data,
  input  wire logic [7:0]  in_row,
  input  wire logic [4:0]  in_column_byte,
  input  wire logic        queue_full,
  input  wire logic        clearing,
  output logic             push,
  output bascd_cmd_t       cmd
);

  logic       accept;
  logic       keep;
  logic [7:0] ybits;

  assign busy   = queue_full | clearing;
  assign accept = start & ~busy;
  assign push   = accept & keep;

  // Scanline bits 5..3 and 2..0 trade places in the bitmap address.
  assign ybits = {in_row[7:6], in_row[2:0], in_row[5:3]};

  always_comb begin
    cmd.kind      = in_opcode;
    cmd.addr      = in_mem_address;
    cmd.attr_addr = ADDR_W'(ATTR_BASE) + ADDR_W'({in_row[7:3], in_column_byte});
    cmd.data      = in_mem_data;
    cmd.row       = in_row;
    cmd.col       = in_column_byte;
    keep          = 1'b0;
    case (in_opcode)
      OP_WRITE: begin
        keep = (in_mem_address < ADDR_W'(STORE_BYTES));
      end
      OP_RENDER: begin
        cmd.addr = {ybits, in_column_byte};
        keep     = (in_row < 8'(SCREEN_ROWS));
      end
      OP_FRAME: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/bascd_queue.sv
// Request queue between the front end and the back end of the screen decoder.
// A small circular buffer of classified requests. Depends on bascd_pkg.
`default_nettype none

module bascd_queue
  import bascd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire bascd_cmd_t push_cmd,
  input  wire logic       pop,
  output logic            head_valid,
  output bascd_cmd_t      head_cmd,
  output logic            full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bascd_cmd_t    slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign head_valid = (count_r != '0);
  assign full       = (count_r == CW'(DEPTH));
  assign head_cmd   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid))
    else $error("queue read while empty");

  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CW'(1))
    else $error("queue fill count did not grow on a lone write");

endmodule

`default_nettype wire

// File: sv/bascd_back.sv
// Back end of the screen decoder: owns the screen store and the frame counter.
// Clears the store after reset, executes queued requests in order and emits
// the eight pixels of each rendered cell. Depends on bascd_pkg.
`default_nettype none

module bascd_back
  import bascd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        head_valid,
  input  wire bascd_cmd_t  head_cmd,
  output logic             pop,
  output logic             clearing,
  output logic             out_valid,
  output logic [7:0]       out_pixel_x,
  output logic [7:0]       out_pixel_y,
  output logic [3:0]       out_colour_index,
  output logic [23:0]      out_rgb,
  output logic             out_last_pixel
);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_RD_ATTR = 3'd2;
  localparam logic [2:0] ST_LOAD    = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  logic [7:0]        store_mem_r [STORE_BYTES];

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [5:0]        frame_r, frame_nxt;
  logic [7:0]        rd_data_r;
  logic [ADDR_W-1:0] attr_addr_r, attr_addr_nxt;
  logic [7:0]        row_r, row_nxt;
  logic [4:0]        col_r, col_nxt;
  logic [7:0]        bits_r, bits_nxt;
  logic [2:0]        ink_r, ink_nxt;
  logic [2:0]        paper_r, paper_nxt;
  logic              bright_r, bright_nxt;
  logic [2:0]        k_r, k_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_pixel_x_r, out_pixel_x_nxt;
  logic [7:0]        out_pixel_y_r, out_pixel_y_nxt;
  logic [3:0]        out_colour_index_r, out_colour_index_nxt;
  logic [23:0]       out_rgb_r, out_rgb_nxt;
  logic              out_last_pixel_r, out_last_pixel_nxt;

  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [ADDR_W-1:0] rd_addr;

  logic              loading;
  logic              swap;
  logic [2:0]        ld_ink;
  logic [2:0]        ld_paper;
  logic [2:0]        pix_colour;
  logic              pix_bright;
  logic [2:0]        pix_k;
  logic [3:0]        pix_idx;

  assign clearing         = (state_r == ST_CLEAR);
  assign out_valid        = out_valid_r;
  assign out_pixel_x      = out_pixel_x_r;
  assign out_pixel_y      = out_pixel_y_r;
  assign out_colour_index = out_colour_index_r;
  assign out_rgb          = out_rgb_r;
  assign out_last_pixel   = out_last_pixel_r;

  // In the load cycle the attribute byte sits in the read register; afterwards
  // the decoded colors come from their own registers.
  assign loading  = (state_r == ST_LOAD);
  assign swap     = frame_r[5] & rd_data_r[7];
  assign ld_ink   = swap ? rd_data_r[5:3] : rd_data_r[2:0];
  assign ld_paper = swap ? rd_data_r[2:0] : rd_data_r[5:3];

  always_comb begin
    if (bits_r[7]) begin
      pix_colour = loading ? ld_ink : ink_r;
    end else begin
      pix_colour = loading ? ld_paper : paper_r;
    end
    pix_bright = loading ? rd_data_r[6] : bright_r;
    pix_k      = loading ? 3'd0 : k_r;
    pix_idx    = {pix_bright, pix_colour};
  end

  always_comb begin
    state_nxt            = state_r;
    clr_cnt_nxt          = clr_cnt_r;
    frame_nxt            = frame_r;
    attr_addr_nxt        = attr_addr_r;
    row_nxt              = row_r;
    col_nxt              = col_r;
    bits_nxt             = bits_r;
    ink_nxt              = ink_r;
    paper_nxt            = paper_r;
    bright_nxt           = bright_r;
    k_nxt                = k_r;
    out_valid_nxt        = 1'b0;
    out_pixel_x_nxt      = {col_r, pix_k};
    out_pixel_y_nxt      = row_r;
    out_colour_index_nxt = pix_idx;
    out_rgb_nxt          = palette_rgb(pix_idx);
    out_last_pixel_nxt   = (pix_k == 3'd7);
    we                   = 1'b0;
    wr_addr              = head_cmd.addr;
    wr_data              = head_cmd.data;
    rd_addr              = head_cmd.addr;
    pop                  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        we          = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = 8'h00;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(STORE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head_cmd.kind)
            OP_WRITE: begin
              we = 1'b1;
            end
            OP_FRAME: begin
              frame_nxt = frame_r + 6'd1;
            end
            OP_RENDER: begin
              // The bitmap byte read is issued in this cycle.
              attr_addr_nxt = head_cmd.attr_addr;
              row_nxt       = head_cmd.row;
              col_nxt       = head_cmd.col;
              state_nxt     = ST_RD_ATTR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RD_ATTR: begin
        rd_addr   = attr_addr_r;
        bits_nxt  = rd_data_r;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        ink_nxt       = ld_ink;
        paper_nxt     = ld_paper;
        bright_nxt    = rd_data_r[6];
        out_valid_nxt = 1'b1;
        bits_nxt      = {bits_r[6:0], 1'b0};
        k_nxt         = 3'd1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        bits_nxt      = {bits_r[6:0], 1'b0};
        k_nxt         = k_r + 3'd1;
        if (k_r == 3'd7) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      frame_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      frame_r     <= frame_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    attr_addr_r        <= attr_addr_nxt;
    row_r              <= row_nxt;
    col_r              <= col_nxt;
    bits_r             <= bits_nxt;
    ink_r              <= ink_nxt;
    paper_r            <= paper_nxt;
    bright_r           <= bright_nxt;
    k_r                <= k_nxt;
    out_pixel_x_r      <= out_pixel_x_nxt;
    out_pixel_y_r      <= out_pixel_y_nxt;
    out_colour_index_r <= out_colour_index_nxt;
    out_rgb_r          <= out_rgb_nxt;
    out_last_pixel_r   <= out_last_pixel_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= store_mem_r[rd_addr];
  end

  a_gap_after_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_pixel_r |=> !out_valid_r)
    else $error("pixel strobe continued past the last pixel of a cell");

  a_pixels_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_pixel_r |=>
      out_valid_r && (out_pixel_x_r == $past(out_pixel_x_r) + 8'd1))
    else $error("cell pixels not emitted on consecutive cycles and positions");

  a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r && !pop)
    else $error("activity during the store clear pass");

endmodule

`default_nettype wire

// File: sv/bitmap_attribute_screen_decode.sv
// Bitmap/attribute screen decoder. A write or frame request takes effect when the back end
// pops it from the queue; a render reads its bitmap byte and then its attribute byte
// from the store before its first pixel strobe rises, followed by the other seven on
// consecutive cycles. The back end handles one request at a time, in queue order.
// After reset, busy stays high during the store clear pass. The result receiver
// cannot stall.
`default_nettype none

module bitmap_attribute_screen_decode
  import bascd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [12:0] in_mem_address,
  input  wire logic [7:0]  in_mem_data,
  input  wire logic [7:0]  in_row,
  input  wire logic [4:0]  in_column_byte,
  output logic             out_valid,
  output logic [7:0]       out_pixel_x,
  output logic [7:0]       out_pixel_y,
  output logic [3:0]       out_colour_index,
  output logic [23:0]      out_rgb,
  output logic             out_last_pixel
);

  logic       push;
  bascd_cmd_t push_cmd;
  logic       pop;
  logic       head_valid;
  bascd_cmd_t head_cmd;
  logic       queue_full;
  logic       clearing;

  bascd_front u_front (
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_mem_address (in_mem_address),
    .in_mem_data    (in_mem_data),
    .in_row         (in_row),
    .in_column_byte (in_column_byte),
    .queue_full     (queue_full),
    .clearing       (clearing),
    .push           (push),
    .cmd            (push_cmd)
  );

  bascd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .full       (queue_full)
  );

  bascd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_cmd         (head_cmd),
    .pop              (pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_colour_index (out_colour_index),
    .out_rgb          (out_rgb),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for bitmap_attribute_screen_decode.
// Drives write, render and frame requests and predicts every pixel from its own screen copy.
// Depends on bascd_pkg and the decoder RTL.
module tb;
  import bascd_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         RANDOM_ITEMS   = 390;
  localparam int         WATCHDOG_LIMIT = 30000;
  localparam int         PRINT_LIMIT    = 40;
  localparam int         DIRECTED_ROWS  = 23;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [3:0]  idx;
    logic [23:0] rgb;
    logic        last;
  } screen_pixel_t;

  // Rows with typed set carry the eight color indices, first pixel in the top nibble.
  typedef struct packed {
    logic [1:0]  op;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [7:0]  row;
    logic [4:0]  col;
    logic        typed;
    logic [31:0] idx;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_opcode = OP_WRITE;
  logic [12:0] in_mem_address = '0;
  logic [7:0]  in_mem_data = '0;
  logic [7:0]  in_row = '0;
  logic [4:0]  in_column_byte = '0;
  logic        out_valid;
  logic [7:0]  out_pixel_x;
  logic [7:0]  out_pixel_y;
  logic [3:0]  out_colour_index;
  logic [23:0] out_rgb;
  logic        out_last_pixel;

  // Sideband that travels with each request: a typed-in pixel pattern, if any.
  logic        req_typed = 1'b0;
  logic [31:0] req_typed_idx = '0;

  logic [7:0]    shadow_store [STORE_BYTES];
  logic [5:0]    frame_count;
  screen_pixel_t expected_pixels [$];
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  bit            no_idle = 1'b0;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_RENDER, 13'd0,    8'h00, 8'd0,   5'd0,  1'b1, 32'h00000000},
    '{OP_RENDER, 13'd0,    8'h00, 8'd191, 5'd31, 1'b1, 32'h00000000},
    '{OP_WRITE,  13'd6144, 8'h47, 8'd0,   5'd0,  1'b0, 32'h0},
    '{OP_WRITE,  13'd0,    8'ha5, 8'd0,   5'd0,  1'b0, 32'h0},
    '{OP_RENDER, 13'd0,    8'h00, 8'd0,   5'd0,  1'b1, 32'hf8f88f8f},
    '{OP_WRITE,  13'd6911, 8'hff, 8'd0,   5'd0,  1'b0, 32'h0},
    '{OP_WRITE,  13'd6143, 8'h00, 8'd0,   5'd0,  1'b0, 32'h0},
    '{OP_RENDER, 13'd0,    8'h00, 8'd191, 5'd31, 1'b1, 32'hffffffff},
    '{OP_WRITE,  13'd6912, 8'h55, 8'd0,   5'd0,  1'b0, 32'h0},
    '{OP_WRITE,  13'd8191, 8'haa, 8'd0,   5'd0,  1'b0, 32'h0},
    '{OP_RENDER, 13'd0,    8'h00, 8'd192, 5'd0,  1'b0, 32'h0},
    '{OP_RENDER, 13'd0,    8'h00, 8'd255, 5'd31, 1'b0, 32'h0},
    '{OP_UNUSED, 13'd8191, 8'hff, 8'd255, 5'd31, 1'b0, 32'h0},
    '{OP_WRITE,  13'd6144, 8'h8a, 8'd0,   5'd0,  1'b0, 32'h0},
    '{OP_RENDER, 13'd0,    8'h00, 8'd0,   5'd0,  1'b1, 32'h21211212},
    '{OP_FRAME,  13'd0,    8'h00, 8'd0,   5'd0,  1'b0, 32'h0},
    '{OP_WRITE,  13'd1792, 8'hff, 8'd0,   5'd0,  1'b0, 32'h0},
    '{OP_RENDER, 13'd0,    8'h00, 8'd7,   5'd0,  1'b0, 32'h0},
    '{OP_WRITE,  13'd6149, 8'h3c, 8'd0,   5'd0,  1'b0, 32'h0},
    '{OP_WRITE,  13'd5,    8'h0f, 8'd0,   5'd0,  1'b0, 32'h0},
    '{OP_RENDER, 13'd0,    8'h00, 8'd0,   5'd5,  1'b0, 32'h0},
    '{OP_FRAME,  13'd0,    8'h00, 8'd0,   5'd0,  1'b0, 32'h0},
    '{OP_RENDER, 13'd0,    8'h00, 8'd0,   5'd0,  1'b0, 32'h0}
  };

  bitmap_attribute_screen_decode dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_mem_address   (in_mem_address),
    .in_mem_data      (in_mem_data),
    .in_row           (in_row),
    .in_column_byte   (in_column_byte),
    .out_valid        (out_valid),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_colour_index (out_colour_index),
    .out_rgb          (out_rgb),
    .out_last_pixel   (out_last_pixel)
  );

  always #10 clk = ~clk;

  // Scanline bits 5..3 and 2..0 trade places in the bitmap address.
  function automatic logic [12:0] bitmap_addr(input logic [7:0] r, input logic [4:0] c);
    return {r[7:6], r[2:0], r[5:3], c};
  endfunction

  function automatic logic [12:0] attr_addr(input logic [7:0] r, input logic [4:0] c);
    return 13'(ATTR_BASE) + {3'b000, r[7:3], c};
  endfunction

  function automatic logic [23:0] colour_rgb(input logic [3:0] idx);
    logic [7:0] level;
    level = idx[3] ? LEVEL_BRIGHT : LEVEL_NORMAL;
    return {idx[1] ? level : 8'h00, idx[2] ? level : 8'h00, idx[0] ? level : 8'h00};
  endfunction

  task automatic push_pixel(input logic [7:0] r, input logic [4:0] c, input int k,
                            input logic [3:0] idx);
    screen_pixel_t px;
    px.x    = {c, 3'(k)};
    px.y    = r;
    px.idx  = idx;
    px.rgb  = colour_rgb(idx);
    px.last = (k == 7);
    expected_pixels.push_back(px);
  endtask

  task automatic predict_request(input logic [1:0] op, input logic [12:0] addr,
                                 input logic [7:0] data, input logic [7:0] r,
                                 input logic [4:0] c);
    logic [7:0] bits;
    logic [7:0] attr;
    logic [2:0] ink;
    logic [2:0] paper;
    case (op)
      OP_WRITE: begin
        if (addr < STORE_BYTES) shadow_store[addr] = data;
      end
      OP_FRAME: begin
        frame_count = frame_count + 6'd1;
      end
      OP_RENDER: begin
        if (r < SCREEN_ROWS) begin
          bits  = shadow_store[bitmap_addr(r, c)];
          attr  = shadow_store[attr_addr(r, c)];
          ink   = attr[2:0];
          paper = attr[5:3];
          // Flashing cells swap ink and paper during the on half of the flash cycle.
          if (frame_count[5] && attr[7]) begin
            ink   = attr[5:3];
            paper = attr[2:0];
          end
          for (int k = 0; k < 8; k++) push_pixel(r, c, k, {attr[6], bits[7-k] ? ink : paper});
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic check_pixel();
    screen_pixel_t px;
    if (expected_pixels.size() == 0) begin
      report_mismatch("pixel with none pending", 32'({out_pixel_y, out_pixel_x}), 32'h0);
      return;
    end
    px = expected_pixels.pop_front();
    if (out_pixel_x !== px.x)
      report_mismatch("pixel_x", 32'(out_pixel_x), 32'(px.x));
    if (out_pixel_y !== px.y)
      report_mismatch("pixel_y", 32'(out_pixel_y), 32'(px.y));
    if (out_colour_index !== px.idx)
      report_mismatch("colour_index", 32'(out_colour_index), 32'(px.idx));
    if (out_rgb !== px.rgb)
      report_mismatch("rgb", 32'(out_rgb), 32'(px.rgb));
    if (out_last_pixel !== px.last)
      report_mismatch("last_pixel", 32'(out_last_pixel), 32'(px.last));
  endtask

  // Checks pixels, predicts accepted requests and watches for a stalled run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) check_pixel();
      if (start && !busy) begin
        if (req_typed) begin
          for (int k = 0; k < 8; k++)
            push_pixel(in_row, in_column_byte, k, req_typed_idx[31-4*k -: 4]);
        end else begin
          predict_request(in_opcode, in_mem_address, in_mem_data, in_row, in_column_byte);
        end
      end
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Returns at the edge where the request is accepted, with start still high.
  task automatic send_request(input logic [1:0] op, input logic [12:0] addr,
                              input logic [7:0] data, input logic [7:0] r,
                              input logic [4:0] c, input logic typed,
                              input logic [31:0] typed_idx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_mem_address <= addr;
    in_mem_data    <= data;
    in_row         <= r;
    in_column_byte <= c;
    req_typed      <= typed;
    req_typed_idx  <= typed_idx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_pixels();
    start <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input logic [1:0] op, input logic [7:0] r, input logic [4:0] c);
    send_request(op, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)), r, c, 1'b0, '0);
  endtask

  initial begin
    int         counted;
    int         pick;
    int         n;
    logic [7:0] r;
    logic [4:0] c;
    logic [12:0] addr;

    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    frame_count = '0;
    counted = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_request(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                   directed_rows[i].row, directed_rows[i].col, directed_rows[i].typed,
                   directed_rows[i].idx);

    // Let the decoder run dry once before the random traffic starts.
    drain_pixels();

    while (counted < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // Fill one cell's bitmap byte and attribute, then render lines of that cell.
        r = 8'($urandom_range(0, 191));
        c = 5'($urandom_range(0, 31));
        send_request(OP_WRITE, bitmap_addr(r, c), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)), 1'b0, '0);
        send_request(OP_WRITE, attr_addr(r, c), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)), 1'b0, '0);
        n = $urandom_range(1, 3);
        for (int j = 0; j < n; j++)
          send_random(OP_RENDER, (j == 0) ? r : {r[7:3], 3'($urandom_range(0, 7))}, c);
        counted += 2 + n;
      end else if (pick < 63) begin
        n = $urandom_range(1, 24);
        for (int j = 0; j < n; j++)
          send_random(OP_FRAME, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
        counted += n;
      end else if (pick < 85) begin
        r = 8'($urandom_range(0, 255));
        send_random(OP_RENDER, r, 5'($urandom_range(0, 31)));
        if (r < SCREEN_ROWS) counted++;
      end else if (pick < 95) begin
        addr = 13'($urandom_range(0, 8191));
        send_request(OP_WRITE, addr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     5'($urandom_range(0, 31)), 1'b0, '0);
        if (addr < STORE_BYTES) counted++;
      end else begin
        send_random(OP_UNUSED, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
      end
    end

    drain_pixels();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
